FILE: hw/rtl/icache_pkg.sv
package icache_pkg;

  localparam int WAYS       = 4;
  localparam int SETS       = 64;
  localparam int LINE_BYTES = 32;

  localparam int ADDR_W     = 32;
  localparam int WORD_W     = 32;
  localparam int LINE_WORDS = LINE_BYTES / 4;
  localparam int OFF_W      = $clog2(LINE_WORDS);
  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W      = ADDR_W - LINE_SHIFT - SET_W;
  localparam int AGE_W      = 8;
  localparam int DATA_AW    = SET_W + WAY_W + OFF_W;

  localparam logic [AGE_W-1:0] AGE_MAX   = '1;
  localparam logic [OFF_W-1:0] FILL_LAST = OFF_W'(LINE_WORDS - 1);

  localparam logic OP_FETCH    = 1'b0;
  localparam logic OP_REFILL   = 1'b1;
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_REFILL = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] tag_row_t;

  typedef struct packed {
    logic             rd_en;
    logic [SET_W-1:0] rd_set;
    logic             wr_en;
    logic [SET_W-1:0] wr_set;
    tag_row_t         wr_row;
  } tag_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [DATA_AW-1:0] rd_addr;
    logic               wr_en;
    logic [DATA_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
  } data_req_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } lookup_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_REFRD,
    ST_TOUCH,
    ST_RESP
  } state_t;

  // The lowest matching way wins, which is why the scan runs downward.
  function automatic lookup_t find_hit(tag_row_t row, logic [TAG_W-1:0] tag);
    lookup_t r;
    r = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row[i].valid && row[i].tag == tag) begin
        r.hit = 1'b1;
        r.way = WAY_W'(i);
      end
    end
    return r;
  endfunction

  // First invalid way, else the oldest way with the first one winning a tie.
  function automatic logic [WAY_W-1:0] pick_victim(tag_row_t row);
    logic             found;
    logic [WAY_W-1:0] inv;
    logic [WAY_W-1:0] best;
    logic [AGE_W-1:0] best_age;
    found    = 1'b0;
    inv      = '0;
    best     = '0;
    best_age = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!row[i].valid && !found) begin
        found = 1'b1;
        inv   = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (row[i].age > best_age) begin
        best_age = row[i].age;
        best     = WAY_W'(i);
      end
    end
    return found ? inv : best;
  endfunction

  function automatic tag_row_t touch_row(tag_row_t row, logic [WAY_W-1:0] way);
    tag_row_t r;
    r = row;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == way) begin
        r[i].age = '0;
      end else if (row[i].valid && row[i].age != AGE_MAX) begin
        r[i].age = row[i].age + 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/icache_tags.sv
module icache_tags import icache_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tag_req_t req,
  output tag_row_t rd_row
);

  tag_row_t         mem [SETS];
  tag_row_t         mem_q;
  logic [SETS-1:0]  row_written;
  logic             written_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_set] <= req.wr_row;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_set];
    end
  end

  // A row that was never written reads as all zero, as after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      written_q   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_written[req.wr_set] <= 1'b1;
      end
      if (req.rd_en) begin
        written_q <= row_written[req.rd_set];
      end
    end
  end

  assign rd_row = written_q ? mem_q : '0;

endmodule

FILE: hw/rtl/icache_data.sv
module icache_data import icache_pkg::*; (
  input  logic              clk,
  input  data_req_t         req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [2**DATA_AW];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: hw/rtl/set_assoc_icache_lru.sv
// A fetch, hit or miss, passes through ST_LOOKUP and ST_RESP; the last refill word
// passes through ST_FILL, ST_REFRD, ST_TOUCH and ST_RESP. Either raises m_tvalid
// from ST_RESP once the output is free. One item is handled at a time; the tag row
// read, update and write-back hold the block for a fetch and the last refill word.
// Reset (rst, synchronous) invalidates all rows at once and clears the pending miss.
module set_assoc_icache_lru import icache_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // fetch_address [31:0], refill_word [63:32]
  input  logic [0:0]  s_tuser,   // op [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // fetch_word [31:0], refill_address [63:32]
  output logic [1:0]  m_tuser    // kind [0], was_hit [1]
);

  state_t             state, state_next;
  logic [ADDR_W-1:0]  addr_q;
  logic [WORD_W-1:0]  rword_q;
  logic [ADDR_W-1:0]  pend_addr;
  logic               miss_pending;
  logic [WAY_W-1:0]   victim;
  logic [OFF_W-1:0]   fill_count;
  logic               res_kind;
  logic               res_hit;
  logic               res_use_data;
  logic [ADDR_W-1:0]  res_raddr;

  tag_req_t           tag_req;
  tag_row_t           tag_row;
  data_req_t          data_req;
  logic [WORD_W-1:0]  data_rd;
  lookup_t            look;
  logic [WAY_W-1:0]   pick;
  tag_row_t           miss_row;

  logic               s_accept;
  logic               out_free;
  logic               in_op;
  logic [ADDR_W-1:0]  in_addr;
  logic [WORD_W-1:0]  in_rword;
  logic [SET_W-1:0]   cur_set, pend_set;
  logic [TAG_W-1:0]   cur_tag;
  logic [OFF_W-1:0]   cur_off, pend_off;

  assign in_op    = s_tuser[0];
  assign in_addr  = s_tdata[31:0];
  assign in_rword = s_tdata[63:32];

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cur_set  = addr_q[LINE_SHIFT +: SET_W];
  assign cur_tag  = addr_q[ADDR_W-1 -: TAG_W];
  assign cur_off  = addr_q[2 +: OFF_W];
  assign pend_set = pend_addr[LINE_SHIFT +: SET_W];
  assign pend_off = pend_addr[2 +: OFF_W];

  icache_tags u_tags (
    .clk    (clk),
    .rst    (rst),
    .req    (tag_req),
    .rd_row (tag_row)
  );

  icache_data u_data (
    .clk     (clk),
    .req     (data_req),
    .rd_data (data_rd)
  );

  always_comb begin
    state_next = state;
    tag_req    = '0;
    data_req   = '0;
    look       = find_hit(tag_row, cur_tag);
    pick       = pick_victim(tag_row);
    miss_row   = tag_row;
    miss_row[pick].valid = 1'b1;
    miss_row[pick].tag   = cur_tag;
    unique case (state)
      ST_IDLE: begin
        tag_req.rd_set = in_addr[LINE_SHIFT +: SET_W];
        if (s_accept) begin
          if (in_op == OP_FETCH && !miss_pending) begin
            tag_req.rd_en = 1'b1;
            state_next    = ST_LOOKUP;
          end else if (in_op == OP_REFILL && miss_pending) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_LOOKUP: begin
        tag_req.wr_en  = 1'b1;
        tag_req.wr_set = cur_set;
        if (look.hit) begin
          tag_req.wr_row   = touch_row(tag_row, look.way);
          data_req.rd_en   = 1'b1;
          data_req.rd_addr = {cur_set, look.way, cur_off};
        end else begin
          tag_req.wr_row = touch_row(miss_row, pick);
        end
        state_next = ST_RESP;
      end
      ST_FILL: begin
        data_req.wr_en   = 1'b1;
        data_req.wr_addr = {pend_set, victim, fill_count};
        data_req.wr_data = rword_q;
        state_next = (fill_count == FILL_LAST) ? ST_REFRD : ST_IDLE;
      end
      ST_REFRD: begin
        // The last word was written in the previous cycle, so this read sees it.
        tag_req.rd_en    = 1'b1;
        tag_req.rd_set   = pend_set;
        data_req.rd_en   = 1'b1;
        data_req.rd_addr = {pend_set, victim, pend_off};
        state_next       = ST_TOUCH;
      end
      ST_TOUCH: begin
        tag_req.wr_en  = 1'b1;
        tag_req.wr_set = pend_set;
        tag_req.wr_row = touch_row(tag_row, victim);
        state_next     = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      miss_pending <= 1'b0;
      pend_addr    <= '0;
      victim       <= '0;
      fill_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_LOOKUP && !look.hit) begin
        miss_pending <= 1'b1;
        pend_addr    <= addr_q;
        victim       <= pick;
        fill_count   <= '0;
      end
      if (state == ST_FILL) begin
        fill_count <= fill_count + 1'b1;
      end
      if (state == ST_TOUCH) begin
        miss_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      addr_q  <= in_addr;
      rword_q <= in_rword;
    end
    if (state == ST_LOOKUP) begin
      res_kind     <= look.hit ? KIND_WORD : KIND_REFILL;
      res_hit      <= look.hit;
      res_use_data <= look.hit;
      res_raddr    <= look.hit ? '0 : {addr_q[ADDR_W-1:LINE_SHIFT], LINE_SHIFT'(0)};
    end
    if (state == ST_TOUCH) begin
      res_kind     <= KIND_WORD;
      res_hit      <= 1'b0;
      res_use_data <= 1'b1;
      res_raddr    <= '0;
    end
    if (state == ST_RESP && out_free) begin
      m_tdata <= {res_raddr, res_use_data ? data_rd : {WORD_W{1'b0}}};
      m_tuser <= {res_hit, res_kind};
    end
  end

endmodule
